/* hw/rtl/ppd_pkg.sv */
package ppd_pkg;

  localparam int NUM_SLOTS_DEF      = 8;
  localparam int PAGE_ADDR_BITS_DEF = 24;
  localparam int PIN_BITS_DEF       = 16;

  localparam int ACTION_BITS = 2;
  localparam int STATUS_BITS = 3;
  localparam int SLOT_BITS   = 3;

  localparam logic [ACTION_BITS-1:0] ACT_GET     = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_FLUSH   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_ADDR   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_POOL_FULL  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_RELEASED   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_NO_MATCH   = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_FLUSH_ENT  = 3'd6;
  localparam logic [STATUS_BITS-1:0] ST_FLUSH_NONE = 3'd7;

  // Search categories that ripple through the row of cells as find-first chains.
  localparam int CAT_HIT_PINNED   = 0;
  localparam int CAT_HIT_UNPINNED = 1;
  localparam int CAT_VICTIM       = 2;
  localparam int CAT_RELEASE      = 3;
  localparam int CAT_FLUSH        = 4;
  localparam int NUM_CATS         = 5;

  typedef logic [NUM_CATS-1:0] cat_vec_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC,
    OP_SET_ONE,
    OP_LOAD,
    OP_DEC,
    OP_FLUSH_START,
    OP_FLUSH_STEP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

/* hw/rtl/ppd_if.sv */
interface ppd_req_if #(
  parameter int ADDR_BITS = ppd_pkg::PAGE_ADDR_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [ppd_pkg::ACTION_BITS-1:0]  action;
  logic [ADDR_BITS-1:0]             page_addr;

  modport source (output valid, action, page_addr, input ready);
  modport sink   (input valid, action, page_addr, output ready);
endinterface

interface ppd_res_if #(
  parameter int ADDR_BITS = ppd_pkg::PAGE_ADDR_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [ppd_pkg::STATUS_BITS-1:0]  status;
  logic [ppd_pkg::SLOT_BITS-1:0]    slot;
  logic                             writeback_valid;
  logic [ADDR_BITS-1:0]             writeback_addr;
  logic                             extend_file;
  logic                             fill_valid;
  logic                             last;

  modport source (output valid, status, slot, writeback_valid, writeback_addr,
                  extend_file, fill_valid, last, input ready);
  modport sink   (input valid, status, slot, writeback_valid, writeback_addr,
                  extend_file, fill_valid, last, output ready);
endinterface

/* hw/rtl/ppd_cell.sv */
module ppd_cell #(
  parameter int PAGE_BITS = ppd_pkg::PAGE_ADDR_BITS_DEF,
  parameter int PIN_BITS  = ppd_pkg::PIN_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ppd_pkg::cell_ctrl_t     ctrl,
  input  logic [PAGE_BITS-1:0]    cmp_page,
  input  ppd_pkg::cat_vec_t       taken_in,
  output ppd_pkg::cat_vec_t       taken_out,
  output ppd_pkg::cat_vec_t       cand,
  output ppd_pkg::cat_vec_t       sel,
  output logic [PAGE_BITS-1:0]    page,
  output logic                    valid
);
  import ppd_pkg::*;

  logic [PIN_BITS-1:0] pin;
  logic                eq;
  logic                pend;
  logic                pinned;

  assign pinned = (pin != '0);

  always_comb begin
    cand                   = '0;
    cand[CAT_HIT_PINNED]   = valid && pinned && eq;
    cand[CAT_HIT_UNPINNED] = valid && !pinned && eq;
    cand[CAT_VICTIM]       = !valid || !pinned;
    cand[CAT_RELEASE]      = valid && eq;
    cand[CAT_FLUSH]        = pend;
  end

  // A cell is selected in a category when it is a candidate and no cell
  // before it in the row has claimed that category.
  assign sel       = cand & ~taken_in;
  assign taken_out = cand | taken_in;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      eq <= (page == cmp_page);
    end
    if ((ctrl.op == OP_LOAD) && sel[CAT_VICTIM]) begin
      page <= cmp_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pin   <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_INC: begin
          if (sel[CAT_HIT_PINNED] && (pin != '1)) pin <= pin + PIN_BITS'(1);
        end
        OP_SET_ONE: begin
          if (sel[CAT_HIT_UNPINNED]) pin <= PIN_BITS'(1);
        end
        OP_LOAD: begin
          if (sel[CAT_VICTIM]) begin
            valid <= 1'b1;
            pin   <= PIN_BITS'(1);
          end
        end
        OP_DEC: begin
          if (sel[CAT_RELEASE] && pinned) pin <= pin - PIN_BITS'(1);
        end
        OP_FLUSH_START: pend <= valid;
        OP_FLUSH_STEP: begin
          if (sel[CAT_FLUSH]) pend <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/pinned_page_directory.sv */
// Channel  Dir  Payload
// req      in   action, page_addr
// res      out  status, slot, writeback_valid, writeback_addr, extend_file,
//               fill_valid, last
// cfg      in   cfg_wr_en, cfg_wr_data (initial_file_pages)
//
// A get or release has an accept step, in which every cell
// compares its page, and an evaluate step that resolves the find-first
// chains through the row of cells and updates the chosen cell.
// A flush gives one item per valid slot, or a single item when none is valid.
// The evaluate step waits while the result register holds an unaccepted item.
// Reset clears all slots and the file length.
module pinned_page_directory #(
  parameter int PAGE_ADDR_BITS = ppd_pkg::PAGE_ADDR_BITS_DEF,
  parameter int PIN_BITS       = ppd_pkg::PIN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  ppd_req_if.sink                    req,
  ppd_res_if.source                  res,
  input  logic                       cfg_wr_en,
  input  logic [PAGE_ADDR_BITS-1:0]  cfg_wr_data
);
  import ppd_pkg::*;

  // The slot field of a result is SLOT_BITS wide, so the row length is fixed.
  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam int FILE_BITS = PAGE_ADDR_BITS + 1;

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t                     state;
  logic [ACTION_BITS-1:0]     act;
  logic [PAGE_ADDR_BITS-1:0]  page_q;
  logic                       addr_bad;
  logic                       addr_ext;
  logic [FILE_BITS-1:0]       file_pages;

  logic                       o_valid;
  logic [STATUS_BITS-1:0]     o_status;
  logic [SLOT_BITS-1:0]       o_slot;
  logic                       o_wb;
  logic [PAGE_ADDR_BITS-1:0]  o_wb_addr;
  logic                       o_ext;
  logic                       o_fill;
  logic                       o_last;

  logic [STATUS_BITS-1:0]     o_status_next;
  logic [SLOT_BITS-1:0]       o_slot_next;
  logic                       o_wb_next;
  logic [PAGE_ADDR_BITS-1:0]  o_wb_addr_next;
  logic                       o_ext_next;
  logic                       o_fill_next;
  logic                       o_last_next;
  logic                       file_inc;

  cell_ctrl_t                 ctrl;
  logic [PAGE_ADDR_BITS-1:0]  cmp_page;
  cat_vec_t                   taken [NUM_SLOTS+1];
  cat_vec_t                   cand  [NUM_SLOTS];
  cat_vec_t                   sel   [NUM_SLOTS];
  logic [PAGE_ADDR_BITS-1:0]  cell_page  [NUM_SLOTS];
  logic                       cell_valid [NUM_SLOTS];

  logic                       accept;
  logic                       out_free;
  logic                       act_known;
  logic                       emit;
  logic                       more_flush;
  cat_vec_t                   any;
  logic [SLOT_BITS-1:0]       slot_of [NUM_CATS];
  logic [PAGE_ADDR_BITS-1:0]  vict_page;
  logic                       vict_valid;
  logic [PAGE_ADDR_BITS-1:0]  flush_page;
  logic                       flush_more;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign out_free   = !o_valid || res.ready;
  assign cmp_page   = (state == S_IDLE) ? req.page_addr : page_q;
  assign taken[0]   = '0;
  assign any        = taken[NUM_SLOTS];
  assign act_known  = (act == ACT_GET) || (act == ACT_RELEASE) || (act == ACT_FLUSH);
  assign emit       = (state == S_EVAL) && out_free && act_known;
  assign more_flush = (act == ACT_FLUSH) && any[CAT_FLUSH] && flush_more;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ppd_cell #(
      .PAGE_BITS (PAGE_ADDR_BITS),
      .PIN_BITS  (PIN_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cmp_page  (cmp_page),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .cand      (cand[g]),
      .sel       (sel[g]),
      .page      (cell_page[g]),
      .valid     (cell_valid[g])
    );
  end

  // The selections are one-hot per category, so an OR over the row encodes them.
  always_comb begin
    for (int c = 0; c < NUM_CATS; c++) slot_of[c] = '0;
    vict_page  = '0;
    vict_valid = 1'b0;
    flush_page = '0;
    flush_more = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      for (int c = 0; c < NUM_CATS; c++) begin
        if (sel[i][c]) slot_of[c] = slot_of[c] | SLOT_BITS'(i);
      end
      vict_page  = vict_page  | (cell_page[i] & {PAGE_ADDR_BITS{sel[i][CAT_VICTIM]}});
      vict_valid = vict_valid | (cell_valid[i] && sel[i][CAT_VICTIM]);
      flush_page = flush_page | (cell_page[i] & {PAGE_ADDR_BITS{sel[i][CAT_FLUSH]}});
      // A flush candidate that finds the category already taken lies after
      // the selected slot, so the selected item is not the last.
      flush_more = flush_more | (cand[i][CAT_FLUSH] && taken[i][CAT_FLUSH]);
    end
  end

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.op     = OP_NONE;
    if (accept && (req.action == ACT_FLUSH)) begin
      ctrl.op = OP_FLUSH_START;
    end else if ((state == S_EVAL) && out_free) begin
      unique case (act)
        ACT_GET: begin
          if (!addr_bad) begin
            priority if (any[CAT_HIT_PINNED])   ctrl.op = OP_INC;
            else if (any[CAT_HIT_UNPINNED])     ctrl.op = OP_SET_ONE;
            else if (any[CAT_VICTIM])           ctrl.op = OP_LOAD;
            else                                ctrl.op = OP_NONE;
          end
        end
        ACT_RELEASE: ctrl.op = OP_DEC;
        ACT_FLUSH:   ctrl.op = OP_FLUSH_STEP;
        default:     ctrl.op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    o_status_next  = ST_HIT;
    o_slot_next    = '0;
    o_wb_next      = 1'b0;
    o_wb_addr_next = '0;
    o_ext_next     = 1'b0;
    o_fill_next    = 1'b0;
    o_last_next    = 1'b1;
    file_inc       = 1'b0;
    unique case (act)
      ACT_GET: begin
        priority if (addr_bad) begin
          o_status_next = ST_BAD_ADDR;
        end else if (any[CAT_HIT_PINNED]) begin
          o_status_next = ST_HIT;
          o_slot_next   = slot_of[CAT_HIT_PINNED];
        end else if (any[CAT_HIT_UNPINNED]) begin
          o_status_next = ST_HIT;
          o_slot_next   = slot_of[CAT_HIT_UNPINNED];
        end else if (any[CAT_VICTIM]) begin
          o_status_next  = ST_MISS;
          o_slot_next    = slot_of[CAT_VICTIM];
          o_wb_next      = vict_valid;
          o_wb_addr_next = vict_valid ? vict_page : '0;
          o_ext_next     = addr_ext;
          o_fill_next    = 1'b1;
          file_inc       = emit && addr_ext;
        end else begin
          o_status_next = ST_POOL_FULL;
        end
      end
      ACT_RELEASE: begin
        if (any[CAT_RELEASE]) begin
          o_status_next = ST_RELEASED;
          o_slot_next   = slot_of[CAT_RELEASE];
        end else begin
          o_status_next = ST_NO_MATCH;
        end
      end
      default: begin
        if (any[CAT_FLUSH]) begin
          o_status_next  = ST_FLUSH_ENT;
          o_slot_next    = slot_of[CAT_FLUSH];
          o_wb_next      = 1'b1;
          o_wb_addr_next = flush_page;
          o_last_next    = !flush_more;
        end else begin
          o_status_next = ST_FLUSH_NONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= req.action;
      page_q   <= req.page_addr;
      addr_bad <= ({1'b0, req.page_addr} > file_pages);
      addr_ext <= ({1'b0, req.page_addr} == file_pages);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      file_pages <= '0;
      o_valid    <= 1'b0;
      o_status   <= ST_HIT;
      o_slot     <= '0;
      o_wb       <= 1'b0;
      o_wb_addr  <= '0;
      o_ext      <= 1'b0;
      o_fill     <= 1'b0;
      o_last     <= 1'b0;
    end else begin
      if (cfg_wr_en) file_pages <= {1'b0, cfg_wr_data};
      else if (file_inc) file_pages <= file_pages + FILE_BITS'(1);
      if (emit) o_valid <= 1'b1;
      else if (res.ready) o_valid <= 1'b0;
      if (emit) begin
        o_status  <= o_status_next;
        o_slot    <= o_slot_next;
        o_wb      <= o_wb_next;
        o_wb_addr <= o_wb_addr_next;
        o_ext     <= o_ext_next;
        o_fill    <= o_fill_next;
        o_last    <= o_last_next;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_EVAL;
        end
        S_EVAL: begin
          // The unused action code gives no item.
          if (!act_known || (out_free && !more_flush)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid           = o_valid;
  assign res.status          = o_status;
  assign res.slot            = o_slot;
  assign res.writeback_valid = o_wb;
  assign res.writeback_addr  = o_wb_addr;
  assign res.extend_file     = o_ext;
  assign res.fill_valid      = o_fill;
  assign res.last            = o_last;

endmodule
